// ===== design/srpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the sensor reply parser and pressure filter.
// No dependencies; every other design file imports this package.
package srpf_pkg;

    localparam int MAX_JOINTS = 4;
    localparam int CHANNELS   = 4;

    localparam int KIND_W   = 2;
    localparam int JOINT_W  = 2;
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int PRESS_W  = 18;
    localparam int MISS_W   = 8;
    localparam int CH_W     = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Event kinds carried on the input channel
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_THRESHOLD = 3'd4;

    // Largest raw sample a valid packet may carry
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'd1023;

    // Multiplier operand and product widths
    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_set_t;

    // Control from the sequencer to the parser
    typedef struct packed {
        logic byte_en;
        logic clear;
    } parse_ctl_t;

endpackage

// ===== design/srpf_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input events and the result items.
// Depends on srpf_pkg for field widths.
interface srpf_in_if;
    import srpf_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [JOINT_W-1:0]  joint_index;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, kind, joint_index, data_byte, input ready);
    modport sink   (input valid, kind, joint_index, data_byte, output ready);
endinterface

interface srpf_out_if;
    import srpf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [JOINT_W-1:0]         joint_out;
    logic                       read_ok;
    logic signed [PRESS_W-1:0]  pressure_a;
    logic signed [PRESS_W-1:0]  pressure_b;
    logic signed [PRESS_W-1:0]  pressure_c;
    logic signed [PRESS_W-1:0]  pressure_d;
    logic [MISS_W-1:0]          miss_count;
    logic                       link_lost;

    modport source (output valid, joint_out, read_ok, pressure_a, pressure_b,
                    pressure_c, pressure_d, miss_count, link_lost, input ready);
    modport sink   (input valid, joint_out, read_ok, pressure_a, pressure_b,
                    pressure_c, pressure_d, miss_count, link_lost, output ready);
endinterface

// ===== design/srpf_parser.sv =====
`timescale 1ns / 1ps
// Reply byte parser: address hunt with a sliding byte pair, payload gather.
// Depends on srpf_pkg.
module srpf_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  srpf_pkg::parse_ctl_t            ctl,
    input  logic [srpf_pkg::JOINT_W-1:0]    joint_index,
    input  logic [srpf_pkg::BYTE_W-1:0]     data_byte,
    input  logic [15:0]                     base_address,
    output srpf_pkg::sample_set_t           samples,
    output logic                            packet_valid
);
    import srpf_pkg::*;

    logic [BYTE_W-1:0]  prev_reg,  prev_next;
    logic [3:0]         count_reg, count_next;
    logic [63:0]        payload_reg, payload_next;
    logic               valid_reg, valid_next;
    sample_set_t        samples_reg, samples_next;
    logic [15:0]        addr;
    logic               all_ok;

    assign addr = base_address - {14'd0, joint_index};

    always_comb
    begin
        prev_next    = prev_reg;
        count_next   = count_reg;
        payload_next = payload_reg;
        valid_next   = valid_reg;
        samples_next = samples_reg;
        all_ok       = 1'b1;
        if (ctl.clear)
        begin
            prev_next  = '0;
            count_next = '0;
            valid_next = 1'b0;
        end
        else if (ctl.byte_en)
        begin
            if (count_reg == 4'd0)
            begin
                if ({prev_reg, data_byte} == addr)
                begin
                    count_next   = 4'd8;
                    payload_next = '0;
                end
                else
                begin
                    prev_next = data_byte;
                end
            end
            else
            begin
                payload_next = {payload_reg[55:0], data_byte};
                count_next   = count_reg - 4'd1;
                if (count_reg == 4'd1)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (payload_next[(3-i)*16 +: 16] > SAMPLE_MAX)
                            all_ok = 1'b0;
                    end
                    for (int i = 0; i < CHANNELS; i++)
                        samples_next[i] = payload_next[(3-i)*16 +: 16];
                    valid_next = all_ok;
                    prev_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            count_reg   <= '0;
            payload_reg <= '0;
            valid_reg   <= 1'b0;
            samples_reg <= '0;
        end
        else
        begin
            prev_reg    <= prev_next;
            count_reg   <= count_next;
            payload_reg <= payload_next;
            valid_reg   <= valid_next;
            samples_reg <= samples_next;
        end
    end

    assign samples      = samples_reg;
    assign packet_valid = valid_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'd8)
        else $error("payload count out of range");

    a_clear_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (count_reg == 4'd0) && !valid_reg && (prev_reg == '0))
        else $error("parser not back to hunting after clear");

    a_valid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (samples_reg[0] <= SAMPLE_MAX))
        else $error("valid packet holds out of range sample");

endmodule

// ===== design/srpf_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on srpf_pkg for operand widths.
module srpf_mul
(
    input  logic                                    clk,
    input  logic signed [srpf_pkg::MUL_W-1:0]       op_a,
    input  logic signed [srpf_pkg::MUL_W-1:0]       op_b,
    output logic signed [srpf_pkg::PROD_W-1:0]      product
);
    import srpf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

// ===== design/sensor_reply_parser_filter.sv =====
`timescale 1ns / 1ps
// Sensor reply parser and pressure filter, top level.
// A received byte goes straight to the parser. An end of reply with a valid packet runs load, gain
// multiply, round, two filter multiplies and sum per channel, then emit; a failed read or timeout copies.
// The shared 19x19 multiplier, three passes per channel, sets the conversion time.
// Reset: configuration returns to its defaults, parser hunts, filter and miss state clear.
module sensor_reply_parser_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    srpf_in_if.sink                             in_ch,
    srpf_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [srpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srpf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import srpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MULG,
        S_ROUND,
        S_MULF,
        S_MULP,
        S_SUM,
        S_READ,
        S_EMIT
    } state_t;

    // Configuration registers
    logic [15:0]    base_reg;
    logic [13:0]    offset_reg;
    logic [17:0]    gain_reg;
    logic [8:0]     alpha_reg;
    logic [7:0]     thresh_reg;

    // Sequencer and datapath registers
    state_t                     state_reg;
    logic [JOINT_W-1:0]         joint_reg;
    logic                       ok_reg;
    logic [CH_W-1:0]            ch_reg;
    logic signed [14:0]         diff_reg;
    logic signed [PRESS_W-1:0]  f_reg;
    logic signed [PRESS_W-1:0]  p_reg;
    logic signed [27:0]         acc_reg;
    logic signed [PRESS_W-1:0]  press_reg [CHANNELS];

    // Per-joint state
    logic signed [PRESS_W-1:0]  filt_reg [MAX_JOINTS*4];
    logic [MISS_W-1:0]          miss_reg [MAX_JOINTS];

    // Output register
    logic                       out_valid_reg;
    logic [JOINT_W-1:0]         out_joint_reg;
    logic                       out_ok_reg;
    logic signed [PRESS_W-1:0]  out_press_reg [4];
    logic [MISS_W-1:0]          out_miss_reg;
    logic                       out_lost_reg;

    // Datapath signals
    logic                       in_xfer;
    logic                       is_event;
    logic                       joint_ok;
    parse_ctl_t                 pctl;
    sample_set_t                samples;
    logic                       packet_valid;
    logic [3:0]                 slot;
    logic [8:0]                 alpha_eff;
    logic [8:0]                 alpha_inv;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   product;
    logic signed [14:0]         diff_next;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [27:0]         sum;
    logic signed [27:0]         sum_sh;
    logic signed [PRESS_W-1:0]  f_new;
    logic [MISS_W-1:0]          miss_cur;
    logic [MISS_W-1:0]          miss_new;
    logic                       slot_free;
    logic                       last_ch;
    logic                       emit_fire;

    function automatic logic signed [PRESS_W-1:0] sat18(input logic signed [PROD_W-1:0] v);
        logic signed [PRESS_W-1:0] r;
        if (v > PROD_W'(131071))
            r = 18'sd131071;
        else if (v < -PROD_W'(131072))
            r = -18'sd131072;
        else
            r = v[PRESS_W-1:0];
        return r;
    endfunction

    // Accept only while the sequencer is idle; bytes still flow while a result waits
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign is_event    = (in_ch.kind == KIND_END) || (in_ch.kind == KIND_TIMEOUT);
    assign joint_ok    = ({1'b0, in_ch.joint_index} < 3'(MAX_JOINTS));

    assign pctl.byte_en = in_xfer && (in_ch.kind == KIND_BYTE);
    assign pctl.clear   = in_xfer && is_event;

    srpf_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pctl),
        .joint_index  (in_ch.joint_index),
        .data_byte    (in_ch.data_byte),
        .base_address (base_reg),
        .samples      (samples),
        .packet_valid (packet_valid)
    );

    srpf_mul u_mul
    (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    assign slot      = {joint_reg, ch_reg};
    assign alpha_eff = (alpha_reg > 9'd256) ? 9'd256 : alpha_reg;
    assign alpha_inv = 9'd256 - alpha_eff;
    assign last_ch   = (ch_reg == CH_W'(CHANNELS - 1));
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign emit_fire = (state_reg == S_EMIT) && slot_free;

    // Valid samples are at most ten bits, so the offset difference fits in 15 bits
    assign diff_next = $signed({1'b0, samples[ch_reg][9:0], 4'd0}) - $signed({1'b0, offset_reg});

    // Round to nearest, ties towards plus infinity, then drop twelve fraction bits
    assign rounded = (product + PROD_W'(2048)) >>> 12;

    // Filter sum: old share from acc_reg, new share on the multiplier output
    assign sum    = acc_reg + $signed(product[27:0]) + 28'sd128;
    assign sum_sh = sum >>> 8;
    assign f_new  = sat18(PROD_W'(sum_sh));

    assign miss_cur = miss_reg[joint_reg];
    assign miss_new = ok_reg ? '0 : ((miss_cur == '1) ? miss_cur : miss_cur + 8'd1);

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MULG:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = $signed({1'b0, gain_reg});
            end
            S_MULF:
            begin
                mul_a = MUL_W'(f_reg);
                mul_b = $signed({10'd0, alpha_inv});
            end
            S_MULP:
            begin
                mul_a = MUL_W'(p_reg);
                mul_b = $signed({10'd0, alpha_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= 16'd65535;
            offset_reg    <= 14'd1638;
            gain_reg      <= 18'd16548;
            alpha_reg     <= 9'd154;
            thresh_reg    <= 8'd50;
            state_reg     <= S_IDLE;
            joint_reg     <= '0;
            ok_reg        <= 1'b0;
            ch_reg        <= '0;
            diff_reg      <= '0;
            f_reg         <= '0;
            p_reg         <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_joint_reg <= '0;
            out_ok_reg    <= 1'b0;
            out_miss_reg  <= '0;
            out_lost_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
                press_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                out_press_reg[i] <= '0;
            for (int i = 0; i < MAX_JOINTS*4; i++)
                filt_reg[i] <= '0;
            for (int i = 0; i < MAX_JOINTS; i++)
                miss_reg[i] <= '0;
        end
        else
        begin
            // Configuration writes; unknown indexes drop
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE_ADDRESS:   base_reg   <= cfg_data[15:0];
                    REG_ZERO_OFFSET:    offset_reg <= cfg_data[13:0];
                    REG_GAIN:           gain_reg   <= cfg_data[17:0];
                    REG_ALPHA:          alpha_reg  <= cfg_data[8:0];
                    REG_LOST_THRESHOLD: thresh_reg <= cfg_data[7:0];
                    default:            ;
                endcase
            end

            // Raise the result at the emit step, retire it once the sink takes it
            out_valid_reg <= emit_fire || (out_valid_reg && !out_ch.ready);

            unique case (state_reg)
                S_IDLE:
                begin
                    // End of reply or timeout for a real joint starts a conversion
                    if (in_xfer && is_event && joint_ok)
                    begin
                        joint_reg <= in_ch.joint_index;
                        ok_reg    <= (in_ch.kind == KIND_END) && packet_valid;
                        ch_reg    <= '0;
                        for (int i = 0; i < CHANNELS; i++)
                            press_reg[i] <= '0;
                        state_reg <= ((in_ch.kind == KIND_END) && packet_valid) ? S_LOAD
                                                                                  : S_READ;
                    end
                end
                S_LOAD:
                begin
                    diff_reg  <= diff_next;
                    f_reg     <= filt_reg[slot];
                    state_reg <= S_MULG;
                end
                S_MULG:
                begin
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    p_reg     <= sat18(rounded);
                    state_reg <= S_MULF;
                end
                S_MULF:
                begin
                    state_reg <= S_MULP;
                end
                S_MULP:
                begin
                    // Hold the old-state share while the new-sample share is formed
                    acc_reg   <= product[27:0];
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    filt_reg[slot]    <= f_new;
                    press_reg[ch_reg] <= f_new;
                    if (last_ch)
                        state_reg <= S_EMIT;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= S_LOAD;
                    end
                end
                S_READ:
                begin
                    // Failed read: show the unchanged filter state
                    press_reg[ch_reg] <= filt_reg[slot];
                    if (last_ch)
                        state_reg <= S_EMIT;
                    else
                        ch_reg <= ch_reg + 2'd1;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        miss_reg[joint_reg] <= miss_new;
                        out_joint_reg       <= joint_reg;
                        out_ok_reg          <= ok_reg;
                        out_miss_reg        <= miss_new;
                        out_lost_reg        <= (miss_new > thresh_reg);
                        for (int i = 0; i < 4; i++)
                            out_press_reg[i] <= (i < CHANNELS) ? press_reg[i] : '0;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.joint_out  = out_joint_reg;
    assign out_ch.read_ok    = out_ok_reg;
    assign out_ch.pressure_a = out_press_reg[0];
    assign out_ch.pressure_b = out_press_reg[1];
    assign out_ch.pressure_c = out_press_reg[2];
    assign out_ch.pressure_d = out_press_reg[3];
    assign out_ch.miss_count = out_miss_reg;
    assign out_ch.link_lost  = out_lost_reg;

    a_ok_clears_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |-> (out_miss_reg == '0))
        else $error("good read left a miss count");

    a_lost_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_lost_reg == (out_miss_reg > thresh_reg)))
        else $error("link lost flag disagrees with miss count");

    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (ch_reg <= CH_W'(CHANNELS - 1)))
        else $error("channel counter out of range");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

endmodule
